[src/gbs_pkg.sv]
// ----------------------------------------------------------------------------
// gbs_pkg
// Shared types and constants for the greedy box suppression block.
// ----------------------------------------------------------------------------
package gbs_pkg;

    localparam int MAX_BOXES  = 64;
    localparam int IDX_W      = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
    localparam int CNT_W      = $clog2(MAX_BOXES + 1);
    localparam int COORD_W    = 12;
    localparam int SCORE_W    = 16;
    localparam int AREA_W     = 2 * COORD_W;
    localparam int RESULT_CAP = 64;
    localparam int NRES_W     = $clog2(RESULT_CAP + 1);
    localparam int KIDX_W     = 6;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_CONF_THR = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OVL_THR  = 1'd1;

    typedef struct packed {
        logic [COORD_W-1:0] box_x;
        logic [COORD_W-1:0] box_y;
        logic [COORD_W-1:0] box_width;
        logic [COORD_W-1:0] box_height;
        logic [SCORE_W-1:0] score;
        logic               final_box;
    } box_t;

    typedef struct packed {
        logic [KIDX_W-1:0] kept_index;
        logic              kept;
        logic              overflowed;
        logic              last_result;
    } result_t;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] w;
        logic [COORD_W-1:0] h;
        logic [SCORE_W-1:0] score;
        logic [AREA_W-1:0]  area;
        logic [IDX_W-1:0]   idx;
        logic               supp;
    } entry_t;

    typedef struct packed {
        logic insert;
        logic shift;
    } cell_ctrl_t;

endpackage

[src/gbs_cell.sv]
// ----------------------------------------------------------------------------
// gbs_cell
// One slot of the ranked box chain: sorted insert on load, shift toward the
// head and append from the overlap unit during suppression.
// ----------------------------------------------------------------------------
module gbs_cell
    import gbs_pkg::*;
(
    input  logic       clk,
    input  cell_ctrl_t ctrl,
    input  logic       valid,
    input  entry_t     new_ent,
    input  logic       prev_ge,
    input  entry_t     prev_ent,
    input  entry_t     next_ent,
    input  logic       app_en,
    input  entry_t     app_ent,
    output logic       ge,
    output entry_t     ent
);

    entry_t ent_reg;
    entry_t ent_next;

    // ge: this slot ranks ahead of the incoming box
    assign ge  = valid && (ent_reg.score >= new_ent.score);
    assign ent = ent_reg;

    always_comb
    begin
        ent_next = ent_reg;
        if (ctrl.insert)
        begin
            if (!ge)
            begin
                ent_next = prev_ge ? new_ent : prev_ent;
            end
        end
        else if (app_en)
        begin
            ent_next = app_ent;
        end
        else if (ctrl.shift)
        begin
            ent_next = next_ent;
        end
    end

    always_ff @(posedge clk)
    begin
        ent_reg <= ent_next;
    end

endmodule

[src/gbs_iou.sv]
// ----------------------------------------------------------------------------
// gbs_iou
// Four stage overlap test: marks the candidate suppressed when
// inter * 65536 > threshold * union (union nonzero) against the reference box.
// ----------------------------------------------------------------------------
module gbs_iou
    import gbs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  entry_t                ref_ent,
    input  entry_t                cand,
    input  logic [SCORE_W-1:0]    thr,
    output logic                  busy,
    output logic                  out_valid,
    output entry_t                out_ent
);

    localparam int E_W = COORD_W + 1;
    localparam int I_W = 2 * E_W;
    localparam int U_W = AREA_W + 1;
    localparam int L_W = I_W + SCORE_W;

    logic [3:0] v_reg;

    logic [COORD_W-1:0] x1, y1;
    logic [E_W-1:0]     ax2, bx2, ay2, by2, x2, y2;
    logic [E_W-1:0]     iw, ih;

    entry_t          e1_reg, e2_reg, e3_reg, e4_reg;
    entry_t          e4_next;
    logic [E_W-1:0]  iw_reg, ih_reg;
    logic [AREA_W-1:0] aa1_reg, aa2_reg;
    logic [I_W-1:0]  inter2_reg, inter3_reg;
    logic [U_W-1:0]  uni3_reg;
    logic [L_W-1:0]  lhs, rhs;

    always_comb
    begin
        x1  = (ref_ent.x > cand.x) ? ref_ent.x : cand.x;
        y1  = (ref_ent.y > cand.y) ? ref_ent.y : cand.y;
        ax2 = E_W'(ref_ent.x) + E_W'(ref_ent.w);
        bx2 = E_W'(cand.x) + E_W'(cand.w);
        ay2 = E_W'(ref_ent.y) + E_W'(ref_ent.h);
        by2 = E_W'(cand.y) + E_W'(cand.h);
        x2  = (ax2 < bx2) ? ax2 : bx2;
        y2  = (ay2 < by2) ? ay2 : by2;
        iw  = (x2 > E_W'(x1)) ? x2 - E_W'(x1) : '0;
        ih  = (y2 > E_W'(y1)) ? y2 - E_W'(y1) : '0;
        lhs = {inter3_reg, {SCORE_W{1'b0}}};
        rhs = L_W'(thr) * L_W'(uni3_reg);
        e4_next      = e3_reg;
        e4_next.supp = e3_reg.supp || ((uni3_reg != '0) && (lhs > rhs));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= {v_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        e1_reg     <= cand;
        iw_reg     <= iw;
        ih_reg     <= ih;
        aa1_reg    <= ref_ent.area;
        e2_reg     <= e1_reg;
        aa2_reg    <= aa1_reg;
        inter2_reg <= iw_reg * ih_reg;
        e3_reg     <= e2_reg;
        inter3_reg <= inter2_reg;
        uni3_reg   <= U_W'(aa2_reg) + U_W'(e2_reg.area) - U_W'(inter2_reg);
        e4_reg     <= e4_next;
    end

    assign busy      = |v_reg;
    assign out_valid = v_reg[3];
    assign out_ent   = e4_reg;

endmodule

[src/greedy_box_suppression.sv]
// ----------------------------------------------------------------------------
// greedy_box_suppression
// Greedy non-maximum suppression over a set of scored boxes.
// ----------------------------------------------------------------------------
// Boxes load one word per cycle into a chain of cells that keeps them ranked
// by score (ties to the earlier load). After the word flagged final_box the
// chain is walked from the head: a kept box is sent once around the remaining
// chain through a four stage overlap unit, and each dropped box is simply
// popped from the head. Loading stalls while a set is being suppressed.
// Results leave through an output register and the last one of each set
// carries last_result.
module greedy_box_suppression
    import gbs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  box_valid,
    output logic                  box_ready,
    input  box_t                  box,
    output logic                  result_valid,
    input  logic                  result_ready,
    output result_t               result,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    typedef enum logic [1:0] {LOAD, POP, SWEEP, DONE} state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [CNT_W-1:0]   send_reg, send_next;
    logic [NRES_W-1:0]  nres_reg, nres_next;
    logic               ovf_reg, ovf_next;
    logic               pend_valid_reg, pend_valid_next;
    logic [IDX_W-1:0]   pend_idx_reg, pend_idx_next;
    logic               out_valid_reg, out_valid_next;
    result_t            out_reg, out_next;
    entry_t             ref_reg, ref_next;
    logic [SCORE_W-1:0] conf_thr_reg, ovl_thr_reg;

    entry_t             ent [MAX_BOXES];
    logic               ge [MAX_BOXES];
    entry_t             new_ent;
    cell_ctrl_t         ctrl;
    logic [CNT_W-1:0]   app_pos;
    logic               popping;
    logic               slot_free;
    logic               kept_now, report, stall;
    logic               pipe_busy, pipe_valid;
    entry_t             pipe_ent;

    assign box_ready    = (state_reg == LOAD);
    assign result_valid = out_valid_reg;
    assign result       = out_reg;
    assign slot_free    = !out_valid_reg || result_ready;

    always_comb
    begin
        new_ent.x     = box.box_x;
        new_ent.y     = box.box_y;
        new_ent.w     = box.box_width;
        new_ent.h     = box.box_height;
        new_ent.score = box.score;
        new_ent.area  = AREA_W'(box.box_width) * AREA_W'(box.box_height);
        new_ent.idx   = IDX_W'(cnt_reg);
        new_ent.supp  = 1'b0;
    end

    assign kept_now = !ent[0].supp && (ent[0].score >= conf_thr_reg);
    assign report   = kept_now && (nres_reg < NRES_W'(RESULT_CAP));
    assign stall    = report && pend_valid_reg && !slot_free;
    assign popping  = (state_reg == SWEEP) && (send_reg != '0);
    assign app_pos  = cnt_reg - CNT_W'(popping);

    always_comb
    begin
        ctrl.insert = (state_reg == LOAD) && box_valid && (cnt_reg < CNT_W'(MAX_BOXES));
        ctrl.shift  = ((state_reg == POP) && (cnt_reg != '0) && !stall) || popping;
    end

    for (genvar i = 0; i < MAX_BOXES; i++)
    begin : g_cell
        gbs_cell u_cell (
            .clk      (clk),
            .ctrl     (ctrl),
            .valid    (CNT_W'(i) < cnt_reg),
            .new_ent  (new_ent),
            .prev_ge  ((i == 0) ? 1'b1 : ge[(i == 0) ? 0 : i - 1]),
            .prev_ent (ent[(i == 0) ? 0 : i - 1]),
            .next_ent (ent[(i == MAX_BOXES - 1) ? i : i + 1]),
            .app_en   ((state_reg == SWEEP) && pipe_valid && (app_pos == CNT_W'(i))),
            .app_ent  (pipe_ent),
            .ge       (ge[i]),
            .ent      (ent[i])
        );
    end

    gbs_iou u_iou (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (popping),
        .ref_ent   (ref_reg),
        .cand      (ent[0]),
        .thr       (ovl_thr_reg),
        .busy      (pipe_busy),
        .out_valid (pipe_valid),
        .out_ent   (pipe_ent)
    );

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        send_next       = send_reg;
        nres_next       = nres_reg;
        ovf_next        = ovf_reg;
        pend_valid_next = pend_valid_reg;
        pend_idx_next   = pend_idx_reg;
        out_valid_next  = out_valid_reg && !result_ready;
        out_next        = out_reg;
        ref_next        = ref_reg;
        unique case (state_reg)
            LOAD:
            begin
                if (box_valid)
                begin
                    if (cnt_reg < CNT_W'(MAX_BOXES))
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (box.final_box)
                    begin
                        state_next = POP;
                    end
                end
            end
            POP:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = DONE;
                end
                else if (!stall)
                begin
                    ref_next = ent[0];
                    cnt_next = cnt_reg - 1'b1;
                    if (report)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_valid_next         = 1'b1;
                            out_next.kept_index    = KIDX_W'(pend_idx_reg);
                            out_next.kept          = 1'b1;
                            out_next.overflowed    = ovf_reg;
                            out_next.last_result   = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_idx_next   = ent[0].idx;
                        nres_next       = nres_reg + 1'b1;
                    end
                    if (kept_now && (cnt_reg > CNT_W'(1)))
                    begin
                        send_next  = cnt_reg - 1'b1;
                        state_next = SWEEP;
                    end
                end
            end
            SWEEP:
            begin
                cnt_next  = cnt_reg - CNT_W'(popping) + CNT_W'(pipe_valid);
                send_next = send_reg - CNT_W'(popping);
                if ((send_reg == '0) && !pipe_busy)
                begin
                    state_next = POP;
                end
            end
            DONE:
            begin
                if (slot_free)
                begin
                    out_valid_next       = 1'b1;
                    out_next.kept_index  = pend_valid_reg ? KIDX_W'(pend_idx_reg) : '0;
                    out_next.kept        = pend_valid_reg;
                    out_next.overflowed  = ovf_reg;
                    out_next.last_result = 1'b1;
                    cnt_next             = '0;
                    ovf_next             = 1'b0;
                    nres_next            = '0;
                    pend_valid_next      = 1'b0;
                    state_next           = LOAD;
                end
            end
            default:
            begin
                state_next = LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= LOAD;
            cnt_reg        <= '0;
            send_reg       <= '0;
            nres_reg       <= '0;
            ovf_reg        <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            conf_thr_reg   <= SCORE_W'(32768);
            ovl_thr_reg    <= SCORE_W'(328);
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            send_reg       <= send_next;
            nres_reg       <= nres_next;
            ovf_reg        <= ovf_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_write)
            begin
                unique case (cfg_index)
                    CFG_CONF_THR: conf_thr_reg <= cfg_data;
                    CFG_OVL_THR:  ovl_thr_reg  <= cfg_data;
                    default:      ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pend_idx_reg <= pend_idx_next;
        out_reg      <= out_next;
        ref_reg      <= ref_next;
    end

endmodule

[tb/greedy_box_suppression_checker.sv]
// ----------------------------------------------------------------------------
// greedy_box_suppression_checker
// Watches the box and result channels, predicts the kept boxes of each set
// with a greedy suppression model of its own, and compares every result word.
// ----------------------------------------------------------------------------
module greedy_box_suppression_checker
    import gbs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  box_valid,
    input  logic                  box_ready,
    input  box_t                  box,
    input  logic                  result_valid,
    input  logic                  result_ready,
    input  result_t               result,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    fail_count,
    output int                    pending
);
    timeunit 1ns;
    timeprecision 1ps;

    box_t                 set_boxes [MAX_BOXES];
    int                   set_size;
    logic                 set_dropped;
    logic [SCORE_W-1:0]   conf_thr;
    logic [SCORE_W-1:0]   ovl_thr;
    result_t              kept_queue [$];

    function automatic logic overlap_exceeds(box_t a, box_t b);
        longint ax, ay, bx, by, x1, y1, x2, y2, iw, ih, inter, uni;
        ax = a.box_x; ay = a.box_y; bx = b.box_x; by = b.box_y;
        x1 = (ax > bx) ? ax : bx;
        y1 = (ay > by) ? ay : by;
        x2 = (ax + a.box_width < bx + b.box_width) ? ax + a.box_width : bx + b.box_width;
        y2 = (ay + a.box_height < by + b.box_height) ? ay + a.box_height
                                                      : by + b.box_height;
        iw = (x2 > x1) ? x2 - x1 : 0;
        ih = (y2 > y1) ? y2 - y1 : 0;
        inter = iw * ih;
        uni = longint'(a.box_width) * a.box_height
            + longint'(b.box_width) * b.box_height - inter;
        if (uni <= 0)
            return 1'b0;
        return inter * 65536 > longint'(ovl_thr) * uni;
    endfunction

    task automatic suppress_set();
        int      order [MAX_BOXES];
        logic    gone [MAX_BOXES];
        int      j, cur, nres;
        result_t r;
        nres = 0;
        for (int i = 0; i < set_size; i++)
        begin
            j = i;
            while (j > 0 && set_boxes[order[j-1]].score < set_boxes[i].score)
            begin
                order[j] = order[j-1];
                j--;
            end
            order[j] = i;
            gone[i] = 1'b0;
        end
        for (int i = 0; i < set_size; i++)
        begin
            cur = order[i];
            if (gone[cur] || set_boxes[cur].score < conf_thr)
                continue;
            if (nres < RESULT_CAP)
            begin
                r.kept_index  = cur[KIDX_W-1:0];
                r.kept        = 1'b1;
                r.overflowed  = set_dropped;
                r.last_result = 1'b0;
                kept_queue.insert(kept_queue.size(), r);
                nres++;
            end
            for (int k = i + 1; k < set_size; k++)
                if (!gone[order[k]] && overlap_exceeds(set_boxes[cur], set_boxes[order[k]]))
                    gone[order[k]] = 1'b1;
        end
        if (nres == 0)
        begin
            r = '0;
            r.overflowed  = set_dropped;
            r.last_result = 1'b1;
            kept_queue.insert(kept_queue.size(), r);
        end
        else
            kept_queue[kept_queue.size()-1].last_result = 1'b1;
        set_size    = 0;
        set_dropped = 1'b0;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            set_size    = 0;
            set_dropped = 1'b0;
            conf_thr    = 16'd32768;
            ovl_thr     = 16'd328;
            fail_count  = 0;
            kept_queue.delete();
            pending     = 0;
        end
        else
        begin
            if (cfg_write)
            begin
                if (cfg_index == CFG_CONF_THR)
                    conf_thr = cfg_data;
                else if (cfg_index == CFG_OVL_THR)
                    ovl_thr = cfg_data;
            end
            if (result_valid && result_ready)
            begin
                if (kept_queue.size() == 0)
                begin
                    $error("unexpected result word %p", result);
                    fail_count = fail_count + 1;
                end
                else
                begin
                    want = kept_queue.pop_front();
                    if (want.kept_index !== result.kept_index)
                    begin
                        $error("kept_index exp %0d got %0d", want.kept_index,
                               result.kept_index);
                        fail_count = fail_count + 1;
                    end
                    if (want.kept !== result.kept)
                    begin
                        $error("kept exp %0d got %0d", want.kept, result.kept);
                        fail_count = fail_count + 1;
                    end
                    if (want.overflowed !== result.overflowed)
                    begin
                        $error("overflowed exp %0d got %0d", want.overflowed,
                               result.overflowed);
                        fail_count = fail_count + 1;
                    end
                    if (want.last_result !== result.last_result)
                    begin
                        $error("last_result exp %0d got %0d", want.last_result,
                               result.last_result);
                        fail_count = fail_count + 1;
                    end
                end
            end
            if (box_valid && box_ready)
            begin
                if (set_size < MAX_BOXES)
                begin
                    set_boxes[set_size] = box;
                    set_size = set_size + 1;
                end
                else
                    set_dropped = 1'b1;
                if (box.final_box)
                    suppress_set();
            end
            pending = kept_queue.size();
        end
    end
endmodule

[tb/greedy_box_suppression_tb.sv]
// ----------------------------------------------------------------------------
// greedy_box_suppression_tb
// Drives box sets with bursty traffic and a stalling receiver, steps the
// thresholds through their extremes between sets, and reports the verdict.
// ----------------------------------------------------------------------------
module greedy_box_suppression_tb;
    import gbs_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic                  clk;
    logic                  rst_n;
    logic                  box_valid;
    logic                  box_ready;
    box_t                  box;
    logic                  result_valid;
    logic                  result_ready;
    result_t               result;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    fail_count;
    int                    pending;
    int                    sent;

    greedy_box_suppression uut (.*);

    greedy_box_suppression_checker checker_i (.*);

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #5ms;
        $display("greedy_box_suppression_tb failed");
        $finish;
    end

    initial
    begin
        result_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            case (($urandom_range(0, 999) / 250))
                0: result_ready <= 1'b1;
                1: result_ready <= $urandom_range(0, 1);
                2: result_ready <= ($urandom_range(0, 3) != 0);
                default: result_ready <= ($urandom_range(0, 4) == 0);
            endcase
        end
    end

    // valid stays up after a word is taken; the next call either
    // replaces the payload or drops valid for a gap
    task automatic send_box(logic [11:0] x, logic [11:0] y, logic [11:0] w,
                            logic [11:0] h, logic [15:0] s, logic fin);
        box_t b;
        b.box_x = x; b.box_y = y; b.box_width = w; b.box_height = h;
        b.score = s; b.final_box = fin;
        if ($urandom_range(0, 3) == 0)
        begin
            box_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        box_valid <= 1'b1;
        box       <= b;
        do @(posedge clk); while (!box_ready);
        sent++;
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
        box_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (200) @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic random_set(int n, int kind);
        logic [11:0] cx, cy;
        cx = 12'($urandom); cy = 12'($urandom);
        for (int i = 0; i < n; i++)
        begin
            if (kind == 0)
                send_box(12'(cx + $urandom_range(0, 20)), 12'(cy + $urandom_range(0, 20)),
                         12'($urandom_range(10, 60)), 12'($urandom_range(10, 60)),
                         16'($urandom), i == n - 1);
            else
                send_box(12'($urandom), 12'($urandom), 12'($urandom), 12'($urandom),
                         ($urandom_range(0, 3) == 0) ? 16'(i / 2) : 16'($urandom),
                         i == n - 1);
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        box_valid = 1'b0;
        box       = '0;
        cfg_write = 1'b0;
        cfg_index = CFG_CONF_THR;
        cfg_data  = '0;
        sent      = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, ties, zero union, nothing kept
        send_box(12'd0, 12'd0, 12'd4095, 12'd4095, 16'hFFFF, 1'b0);
        send_box(12'd10, 12'd10, 12'd100, 12'd100, 16'hFFFF, 1'b0);
        send_box(12'd4095, 12'd4095, 12'd4095, 12'd4095, 16'h8000, 1'b0);
        send_box(12'd5, 12'd5, 12'd0, 12'd0, 16'h9000, 1'b0);
        send_box(12'd5, 12'd5, 12'd0, 12'd0, 16'h9000, 1'b1);
        send_box(12'd0, 12'd0, 12'd10, 12'd10, 16'h0000, 1'b0);
        send_box(12'd0, 12'd0, 12'd10, 12'd10, 16'h7FFF, 1'b1);
        send_box(12'hAAA, 12'h555, 12'h555, 12'hAAA, 16'hAAAA, 1'b1);
        write_reg(CFG_CONF_THR, 16'd0);
        write_reg(CFG_OVL_THR, 16'd0);
        send_box(12'h555, 12'hAAA, 12'hAAA, 12'h555, 16'h5555, 1'b0);
        send_box(12'h560, 12'hAB0, 12'h100, 12'h100, 16'h5555, 1'b0);
        send_box(12'd0, 12'd0, 12'd0, 12'd0, 16'h0000, 1'b1);
        // overflow: 66 loads into a 64 entry store
        write_reg(CFG_OVL_THR, 16'hFFFF);
        for (int i = 0; i < 66; i++)
            send_box(12'($urandom), 12'($urandom), 12'($urandom), 12'($urandom),
                     16'($urandom), i == 65);
        write_reg(CFG_CONF_THR, 16'hFFFF);
        random_set(4, 1);

        for (int p = 0; p < 6; p++)
        begin
            write_reg(CFG_CONF_THR, (p == 5) ? 16'd65535 : 16'($urandom_range(0, 40000)));
            write_reg(CFG_OVL_THR, (p == 0) ? 16'd0 : 16'($urandom_range(0, 40000)));
            for (int s = 0; s < 2; s++)
                random_set($urandom_range(1, 12), ($urandom_range(0, 3) == 0));
        end

        box_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (300) @(posedge clk);
        if (fail_count == 0)
            $display("greedy_box_suppression_tb passed");
        else
            $display("greedy_box_suppression_tb failed");
        $finish;
    end
endmodule

[filelist.f]
src/gbs_pkg.sv
src/gbs_cell.sv
src/gbs_iou.sv
src/greedy_box_suppression.sv
tb/greedy_box_suppression_checker.sv
tb/greedy_box_suppression_tb.sv
